// ===== rtl/core/checked_infix_expression_evaluator_unit_assert.svh =====
// assertion macros shared by the checker
`ifndef CHECKED_INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define CHECKED_INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define CIE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cie assertion failed");

// next-cycle implication
`define CIE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cie assertion failed");

`endif

// ===== rtl/core/cie_pkg.sv =====
package cie_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int AD_W        = $clog2(STACK_DEPTH);
  localparam int VAL_W       = 48;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_W       = VAL_W - FRAC_BITS;
  localparam int MUL_STEPS   = VAL_W;
  localparam int DIV_STEPS   = VAL_W + FRAC_BITS;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam int MAG_W       = 2 * VAL_W - FRAC_BITS;
  localparam int BAL_W       = 16;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    OP_PAREN = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PAREN     = 3'd1,
    ST_ILLEGAL   = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_MALFORMED = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,
    S_RD,
    S_ALU,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    M_PAREN,
    M_OP,
    M_FINAL
  } mode_t;

  typedef struct packed {
    logic ill;
    logic dz;
    logic mal;
    logic ovf;
  } err_t;

  typedef struct packed {
    logic                    start;
    op_t                     op;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                    done;
    logic                    ovf;
    logic                    dz;
    logic signed [VAL_W-1:0] value;
  } alu_rsp_t;

endpackage

// ===== rtl/core/cie_alu.sv =====
module cie_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  cie_pkg::alu_req_t req,
  output cie_pkg::alu_rsp_t rsp
);

  localparam int VW = cie_pkg::VAL_W;
  localparam int MW = cie_pkg::MAG_W;
  localparam int DS = cie_pkg::DIV_STEPS;
  localparam int CW = cie_pkg::CNT_W;

  logic              busy_r;
  logic              is_div_r;
  logic              neg_r;
  logic [CW-1:0]     cnt_r;
  logic [2*VW-1:0]   p_r;
  logic [VW-1:0]     ub_r;
  logic [VW-1:0]     rem_r;
  logic [DS-1:0]     dvd_r;
  logic [DS-1:0]     q_r;
  cie_pkg::alu_rsp_t rsp_r;

  logic [VW-1:0]   ua, ub;
  logic            neg;
  logic [VW:0]     sum, smag;
  logic [VW:0]     as_res;
  logic [VW:0]     hsum;
  logic [2*VW-1:0] p_nxt;
  logic [VW:0]     rs, rd;
  logic            ge;
  logic [VW-1:0]   rem_nxt;
  logic [DS-1:0]   q_nxt;
  logic [VW:0]     mul_res, div_res;

  // saturate a magnitude into the signed range, returns {overflow, value}
  function automatic logic [VW:0] sat(input logic sneg, input logic [MW-1:0] mag);
    logic [MW-1:0] lim;
    logic          o;
    logic [VW-1:0] m;
    lim = sneg ? (MW'(1) << (VW - 1)) : ((MW'(1) << (VW - 1)) - MW'(1));
    o   = mag > lim;
    m   = o ? lim[VW-1:0] : mag[VW-1:0];
    return {o, (sneg ? (~m + VW'(1)) : m)};
  endfunction

  always_comb begin
    ua  = req.a[VW-1] ? (~req.a + VW'(1)) : req.a;
    ub  = req.b[VW-1] ? (~req.b + VW'(1)) : req.b;
    neg = req.a[VW-1] ^ req.b[VW-1];
    if (req.op == cie_pkg::OP_SUB) begin
      sum = {req.a[VW-1], req.a} - {req.b[VW-1], req.b};
    end else begin
      sum = {req.a[VW-1], req.a} + {req.b[VW-1], req.b};
    end
    smag   = sum[VW] ? (~sum + (VW+1)'(1)) : sum;
    as_res = sat(sum[VW], MW'(smag));

    hsum  = {1'b0, p_r[2*VW-1:VW]} + (p_r[0] ? {1'b0, ub_r} : '0);
    p_nxt = {hsum, p_r[VW-1:1]};

    rs      = {rem_r, dvd_r[DS-1]};
    ge      = rs >= {1'b0, ub_r};
    rd      = ge ? (rs - {1'b0, ub_r}) : rs;
    rem_nxt = rd[VW-1:0];
    q_nxt   = {q_r[DS-2:0], ge};

    mul_res = sat(neg_r, p_nxt[2*VW-1:cie_pkg::FRAC_BITS]);
    div_res = sat(neg_r, MW'(q_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rsp_r  <= '0;
    end else begin
      if (req.start) begin
        neg_r <= neg;
        ub_r  <= ub;
        case (req.op)
          cie_pkg::OP_ADD, cie_pkg::OP_SUB: begin
            rsp_r <= {1'b1, as_res[VW], 1'b0, as_res[VW-1:0]};
          end
          cie_pkg::OP_MUL: begin
            busy_r     <= 1'b1;
            is_div_r   <= 1'b0;
            p_r        <= (2*VW)'(ua);
            cnt_r      <= CW'(cie_pkg::MUL_STEPS - 1);
            rsp_r.done <= 1'b0;
          end
          cie_pkg::OP_DIV: begin
            if (ub == '0) begin
              rsp_r <= {1'b1, 1'b0, 1'b1, {VW{1'b0}}};
            end else begin
              busy_r     <= 1'b1;
              is_div_r   <= 1'b1;
              dvd_r      <= DS'(ua) << cie_pkg::FRAC_BITS;
              rem_r      <= '0;
              q_r        <= '0;
              cnt_r      <= CW'(DS - 1);
              rsp_r.done <= 1'b0;
            end
          end
          default: begin
            rsp_r <= {1'b1, 1'b0, 1'b0, {VW{1'b0}}};
          end
        endcase
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (is_div_r) begin
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          dvd_r <= dvd_r << 1;
        end else begin
          p_r <= p_nxt;
        end
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          if (is_div_r) begin
            rsp_r <= {1'b1, div_res[VW], 1'b0, div_res[VW-1:0]};
          end else begin
            rsp_r <= {1'b1, mul_res[VW], 1'b0, mul_res[VW-1:0]};
          end
        end else begin
          rsp_r.done <= 1'b0;
        end
      end else begin
        rsp_r.done <= 1'b0;
      end
    end
  end

  assign rsp = rsp_r;

endmodule

// ===== rtl/core/checked_infix_expression_evaluator_unit.sv =====
// channel | ports                                   | direction
// input   | in_valid in_stall in_char_code in_last_char | into block
// result  | out_valid out_stall out_value out_status     | out of block
//
// a digit or '(' or an illegal character not marked last is taken without a stall
// each operator reduction for +, -, * and / stalls the input until the arithmetic unit is done
// one shared arithmetic unit and a single write port per stack serve every reduction
// a last character adds the final reduction before the item is emitted
// rst_n is synchronous and clears all control state, no clearing pass
// in_stall is high while a character is being reduced or a result waits
module checked_infix_expression_evaluator_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [7:0]                             in_char_code,
  input  logic                                   in_last_char,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [cie_pkg::VAL_W-1:0]       out_value,
  output logic [2:0]                             out_status
);

  localparam int VW = cie_pkg::VAL_W;
  localparam int SW = cie_pkg::SP_W;
  localparam int AW = cie_pkg::AD_W;
  localparam int AC = cie_pkg::ACC_W;
  localparam int SD = cie_pkg::STACK_DEPTH;
  localparam logic [AC-1:0] ACC_LIM = {1'b0, {(AC-1){1'b1}}};

  cie_pkg::state_t state_r, state_nxt;
  cie_pkg::mode_t  mode_r, mode_nxt;
  logic            last_r, last_nxt;
  cie_pkg::op_t    pend_op_r, pend_op_nxt;
  cie_pkg::op_t    alu_op_r, alu_op_nxt;
  logic [SW-1:0]   oc_r, oc_nxt;
  logic [SW-1:0]   vc_r, vc_nxt;
  logic [AC-1:0]   acc_r, acc_nxt;
  logic            pnd_r, pnd_nxt;
  logic [cie_pkg::BAL_W-1:0] bal_r, bal_nxt;
  cie_pkg::err_t   err_r, err_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic signed [VW-1:0] out_value_r, out_value_nxt;
  cie_pkg::status_t out_status_r, out_status_nxt;

  cie_pkg::op_t         ostk_r [SD];
  logic signed [VW-1:0] vstk [SD];
  logic signed [VW-1:0] rd_a_r, rd_b_r;

  logic                 os_we;
  logic [AW-1:0]        os_wa;
  cie_pkg::op_t         os_wd;
  logic                 vs_we;
  logic [AW-1:0]        vs_wa;
  logic signed [VW-1:0] vs_wd;

  logic [SW-1:0]   vcm1, vcm2, ocm1;
  cie_pkg::op_t    top_op;
  logic            has_op;
  logic            is_dig;
  logic [AC+3:0]   acc_ext, acc_wide;
  logic [AC-1:0]   acc_upd, fval;
  logic            flush;
  logic            do_apply, do_post;
  cie_pkg::op_t    apply_op;
  cie_pkg::op_t    char_op;
  logic            fin_mal;

  cie_pkg::alu_req_t alu_req;
  cie_pkg::alu_rsp_t alu_rsp;

  function automatic logic [1:0] prec(input cie_pkg::op_t op);
    case (op)
      cie_pkg::OP_MUL, cie_pkg::OP_DIV: prec = 2'd2;
      cie_pkg::OP_ADD, cie_pkg::OP_SUB: prec = 2'd1;
      default:                          prec = 2'd0;
    endcase
  endfunction

  cie_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  always_comb begin
    vcm1   = vc_r - SW'(1);
    vcm2   = vc_r - SW'(2);
    ocm1   = oc_r - SW'(1);
    top_op = ostk_r[ocm1[AW-1:0]];
    has_op = oc_r != '0;

    is_dig   = in_char_code inside {[cie_pkg::CH_ZERO:cie_pkg::CH_NINE]};
    acc_ext  = (AC+4)'(acc_r);
    acc_wide = (acc_ext << 3) + (acc_ext << 1) + (AC+4)'(in_char_code[3:0]);
    acc_upd  = (acc_wide > (AC+4)'(ACC_LIM)) ? ACC_LIM : acc_wide[AC-1:0];
    flush    = is_dig ? in_last_char : pnd_r;
    fval     = is_dig ? acc_upd : acc_r;

    case (in_char_code)
      cie_pkg::CH_ADD: char_op = cie_pkg::OP_ADD;
      cie_pkg::CH_SUB: char_op = cie_pkg::OP_SUB;
      cie_pkg::CH_MUL: char_op = cie_pkg::OP_MUL;
      default:         char_op = cie_pkg::OP_DIV;
    endcase

    state_nxt      = state_r;
    mode_nxt       = mode_r;
    last_nxt       = last_r;
    pend_op_nxt    = pend_op_r;
    alu_op_nxt     = alu_op_r;
    oc_nxt         = oc_r;
    vc_nxt         = vc_r;
    acc_nxt        = acc_r;
    pnd_nxt        = pnd_r;
    bal_nxt        = bal_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    os_we          = 1'b0;
    os_wa          = oc_r[AW-1:0];
    os_wd          = pend_op_r;
    vs_we          = 1'b0;
    vs_wa          = vc_r[AW-1:0];
    vs_wd          = alu_rsp.value;
    do_apply       = 1'b0;
    do_post        = 1'b0;
    apply_op       = top_op;
    fin_mal        = err_r.mal | (vc_r != SW'(1));
    alu_req        = '0;
    alu_req.op     = alu_op_r;
    alu_req.a      = rd_a_r;
    alu_req.b      = rd_b_r;

    case (state_r)
      cie_pkg::S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last_char;
          if (flush) begin
            acc_nxt = '0;
            pnd_nxt = 1'b0;
            if (vc_r >= SW'(SD)) begin
              err_nxt.ovf = 1'b1;
            end else begin
              vs_we  = 1'b1;
              vs_wd  = VW'(fval) << cie_pkg::FRAC_BITS;
              vc_nxt = vc_r + SW'(1);
            end
          end else if (is_dig) begin
            acc_nxt = acc_upd;
            pnd_nxt = 1'b1;
          end
          if (is_dig && (acc_wide > (AC+4)'(ACC_LIM))) begin
            err_nxt.ovf = 1'b1;
          end
          mode_nxt  = cie_pkg::M_FINAL;
          state_nxt = in_last_char ? cie_pkg::S_LOOP : cie_pkg::S_IDLE;
          if (!is_dig) begin
            case (in_char_code)
              cie_pkg::CH_LPAREN: begin
                bal_nxt = bal_r + cie_pkg::BAL_W'(1);
                if (oc_r >= SW'(SD)) begin
                  err_nxt.ovf = 1'b1;
                end else begin
                  os_we  = 1'b1;
                  os_wd  = cie_pkg::OP_PAREN;
                  oc_nxt = oc_r + SW'(1);
                end
              end
              cie_pkg::CH_RPAREN: begin
                bal_nxt   = bal_r - cie_pkg::BAL_W'(1);
                mode_nxt  = cie_pkg::M_PAREN;
                state_nxt = cie_pkg::S_LOOP;
              end
              cie_pkg::CH_ADD, cie_pkg::CH_SUB, cie_pkg::CH_MUL, cie_pkg::CH_DIV: begin
                pend_op_nxt = char_op;
                mode_nxt    = cie_pkg::M_OP;
                state_nxt   = cie_pkg::S_LOOP;
              end
              default: begin
                err_nxt.ill = 1'b1;
              end
            endcase
          end
        end
      end
      cie_pkg::S_LOOP: begin
        case (mode_r)
          cie_pkg::M_PAREN: begin
            if (!has_op) begin
              err_nxt.mal = 1'b1;
              do_post     = 1'b1;
            end else begin
              oc_nxt = ocm1;
              if (top_op == cie_pkg::OP_PAREN) begin
                do_post = 1'b1;
              end else begin
                do_apply = 1'b1;
              end
            end
          end
          cie_pkg::M_OP: begin
            if (has_op && (top_op != cie_pkg::OP_PAREN) &&
                (prec(pend_op_r) <= prec(top_op))) begin
              oc_nxt   = ocm1;
              do_apply = 1'b1;
            end else begin
              do_post = 1'b1;
              if (oc_r >= SW'(SD)) begin
                err_nxt.ovf = 1'b1;
              end else begin
                os_we  = 1'b1;
                oc_nxt = oc_r + SW'(1);
              end
            end
          end
          default: begin
            if (!has_op) begin
              state_nxt = cie_pkg::S_DONE;
            end else begin
              oc_nxt = ocm1;
              if (top_op == cie_pkg::OP_PAREN) begin
                err_nxt.mal = 1'b1;
                state_nxt   = cie_pkg::S_DONE;
              end else begin
                do_apply = 1'b1;
              end
            end
          end
        endcase
        if (do_post) begin
          mode_nxt  = cie_pkg::M_FINAL;
          state_nxt = last_r ? cie_pkg::S_LOOP : cie_pkg::S_IDLE;
        end
        if (do_apply) begin
          if (vc_r < SW'(2)) begin
            err_nxt.mal = 1'b1;
          end else begin
            alu_op_nxt = apply_op;
            state_nxt  = cie_pkg::S_RD;
          end
        end
      end
      cie_pkg::S_RD: begin
        alu_req.start = 1'b1;
        state_nxt     = cie_pkg::S_ALU;
      end
      cie_pkg::S_ALU: begin
        if (alu_rsp.done) begin
          vs_we       = 1'b1;
          vs_wa       = vcm2[AW-1:0];
          vs_wd       = alu_rsp.value;
          vc_nxt      = vcm1;
          err_nxt.ovf = err_r.ovf | alu_rsp.ovf;
          err_nxt.dz  = err_r.dz | alu_rsp.dz;
          state_nxt   = cie_pkg::S_LOOP;
        end
      end
      cie_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          if (bal_r != '0) begin
            out_status_nxt = cie_pkg::ST_PAREN;
          end else if (err_r.ill) begin
            out_status_nxt = cie_pkg::ST_ILLEGAL;
          end else if (err_r.dz) begin
            out_status_nxt = cie_pkg::ST_DIVZERO;
          end else if (fin_mal) begin
            out_status_nxt = cie_pkg::ST_MALFORMED;
          end else if (err_r.ovf) begin
            out_status_nxt = cie_pkg::ST_OVERFLOW;
          end else begin
            out_status_nxt = cie_pkg::ST_OK;
            out_value_nxt  = rd_b_r;
          end
          oc_nxt    = '0;
          vc_nxt    = '0;
          acc_nxt   = '0;
          pnd_nxt   = 1'b0;
          bal_nxt   = '0;
          err_nxt   = '0;
          last_nxt  = 1'b0;
          state_nxt = cie_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cie_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cie_pkg::S_IDLE;
      mode_r      <= cie_pkg::M_FINAL;
      last_r      <= 1'b0;
      oc_r        <= '0;
      vc_r        <= '0;
      acc_r       <= '0;
      pnd_r       <= 1'b0;
      bal_r       <= '0;
      err_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      last_r      <= last_nxt;
      oc_r        <= oc_nxt;
      vc_r        <= vc_nxt;
      acc_r       <= acc_nxt;
      pnd_r       <= pnd_nxt;
      bal_r       <= bal_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_op_r    <= pend_op_nxt;
    alu_op_r     <= alu_op_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    if (os_we) begin
      ostk_r[os_wa] <= os_wd;
    end
  end

  // value stack, registered reads at the two top entries
  always_ff @(posedge clk) begin
    if (vs_we) begin
      vstk[vs_wa] <= vs_wd;
    end
    rd_a_r <= vstk[vcm2[AW-1:0]];
    rd_b_r <= vstk[vcm1[AW-1:0]];
  end

  assign in_stall   = state_r != cie_pkg::S_IDLE;
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// ===== rtl/core/cie_checker.sv =====
`include "checked_infix_expression_evaluator_unit_assert.svh"

module cie_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [7:0]                       in_char_code,
  input logic                             in_last_char,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [cie_pkg::VAL_W-1:0] out_value,
  input logic [2:0]                       out_status
);

  logic in_acc;
  logic dig;

  assign in_acc = in_valid && !in_stall;
  assign dig    = (in_char_code >= cie_pkg::CH_ZERO) && (in_char_code <= cie_pkg::CH_NINE);

  `CIE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_status))
  `CIE_ASSERT_IMP(a_err_zero, out_valid && (out_status != cie_pkg::ST_OK), out_value == '0)
  `CIE_ASSERT_IMP(a_status_range, out_valid, out_status <= cie_pkg::ST_OVERFLOW)
  `CIE_ASSERT_NXT(a_last_busy, in_acc && in_last_char, in_stall)
  `CIE_ASSERT_NXT(a_digit_fast, in_acc && !in_last_char && dig, !in_stall)

endmodule

bind checked_infix_expression_evaluator_unit cie_checker u_cie_checker (.*);

// ===== test/checked_infix_expression_evaluator_unit_checker.sv =====
`timescale 1ns / 100ps

module checked_infix_expression_evaluator_unit_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [7:0]                        in_char_code,
  input  logic                              in_last_char,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [cie_pkg::VAL_W-1:0]  out_value,
  input  logic [2:0]                        out_status,
  output int                                fail_count,
  output int                                pending_results
);

  localparam logic [47:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_LIM = 48'h8000_0000_0000;
  localparam int          FB      = cie_pkg::FRAC_BITS;
  localparam int          DEPTH   = cie_pkg::STACK_DEPTH;

  typedef struct {
    logic signed [47:0] value;
    logic [2:0]         status;
  } eval_result_t;

  cie_pkg::op_t       ops[DEPTH];
  logic signed [47:0] vals[DEPTH];
  int                 op_depth;
  int                 val_depth;
  logic [47:0]        number_acc;
  bit                 number_open;
  logic [15:0]        balance;
  bit                 f_ill, f_dz, f_mal, f_ovf;
  eval_result_t       expected_results[$];

  assign pending_results = expected_results.size();

  function automatic int rank(cie_pkg::op_t op);
    if (op == cie_pkg::OP_MUL || op == cie_pkg::OP_DIV) return 2;
    if (op == cie_pkg::OP_ADD || op == cie_pkg::OP_SUB) return 1;
    return -1;
  endfunction

  function automatic logic [95:0] mag(logic signed [47:0] v);
    return v < 0 ? 96'(-$signed({v[47], v})) : 96'(v);
  endfunction

  task automatic saturate(input bit neg, input logic [95:0] m, output logic signed [47:0] r);
    logic [95:0] lim;
    lim = neg ? 96'(NEG_LIM) : 96'(POS_LIM);
    if (m > lim) begin
      f_ovf = 1;
      m = lim;
    end
    r = neg ? 48'(-m) : 48'(m);
  endtask

  task automatic clear_state();
    op_depth = 0;
    val_depth = 0;
    number_acc = 0;
    number_open = 0;
    balance = 0;
    {f_ill, f_dz, f_mal, f_ovf} = 0;
  endtask

  task automatic push_val(logic signed [47:0] v);
    if (val_depth >= DEPTH) f_ovf = 1;
    else begin
      vals[val_depth] = v;
      val_depth++;
    end
  endtask

  task automatic push_op(cie_pkg::op_t op);
    if (op_depth >= DEPTH) f_ovf = 1;
    else begin
      ops[op_depth] = op;
      op_depth++;
    end
  endtask

  task automatic reduce(cie_pkg::op_t op);
    logic signed [48:0]  s;
    logic signed [47:0]  a, b, r;
    logic [95:0]         ma, mb, p, q, rem;
    bit                  neg;
    if (val_depth < 2) begin
      f_mal = 1;
      return;
    end
    b = vals[val_depth - 1];
    a = vals[val_depth - 2];
    neg = (a < 0) != (b < 0);
    ma = mag(a);
    mb = mag(b);
    case (op)
      cie_pkg::OP_ADD, cie_pkg::OP_SUB: begin
        s = (op == cie_pkg::OP_ADD) ? 49'(a) + 49'(b) : 49'(a) - 49'(b);
        saturate(s < 0, s < 0 ? 96'(-s) : 96'(s), r);
      end
      cie_pkg::OP_MUL: begin
        p = (ma * mb) >> FB;
        saturate(neg, p, r);
      end
      default: begin
        if (mb == 0) begin
          f_dz = 1;
          r = 0;
        end else begin
          q = 0;
          rem = 0;
          for (int i = 47 + FB; i >= 0; i--) begin
            rem = (rem << 1) | ((i >= FB) ? ((ma >> (i - FB)) & 1) : 0);
            q = q << 1;
            if (rem >= mb) begin
              rem -= mb;
              q |= 1;
            end
            if (q > 96'(NEG_LIM)) break;
          end
          saturate(neg, q, r);
        end
      end
    endcase
    val_depth--;
    vals[val_depth - 1] = r;
  endtask

  task automatic close_number();
    if (number_open) begin
      push_val(48'(number_acc << FB));
      number_acc = 0;
      number_open = 0;
    end
  endtask

  task automatic unwind(output bit found);
    cie_pkg::op_t op;
    found = 0;
    while (op_depth > 0) begin
      op_depth--;
      op = ops[op_depth];
      if (op == cie_pkg::OP_PAREN) begin
        found = 1;
        return;
      end
      reduce(op);
    end
  endtask

  task automatic evaluate_char(logic [7:0] c, logic last);
    cie_pkg::op_t op;
    bit           found;
    eval_result_t res;
    if (c >= cie_pkg::CH_ZERO && c <= cie_pkg::CH_NINE) begin
      number_acc = number_acc * 10 + (c - cie_pkg::CH_ZERO);
      if (number_acc > (POS_LIM >> FB)) begin
        number_acc = POS_LIM >> FB;
        f_ovf = 1;
      end
      number_open = 1;
    end else begin
      close_number();
      if (c == cie_pkg::CH_LPAREN) begin
        push_op(cie_pkg::OP_PAREN);
        balance++;
      end else if (c == cie_pkg::CH_RPAREN) begin
        balance--;
        unwind(found);
        if (!found) f_mal = 1;
      end else if (c == cie_pkg::CH_ADD || c == cie_pkg::CH_SUB ||
                   c == cie_pkg::CH_MUL || c == cie_pkg::CH_DIV) begin
        op = c == cie_pkg::CH_ADD ? cie_pkg::OP_ADD :
             c == cie_pkg::CH_SUB ? cie_pkg::OP_SUB :
             c == cie_pkg::CH_MUL ? cie_pkg::OP_MUL : cie_pkg::OP_DIV;
        while (op_depth > 0 && ops[op_depth - 1] != cie_pkg::OP_PAREN &&
               rank(op) <= rank(ops[op_depth - 1])) begin
          op_depth--;
          reduce(ops[op_depth]);
        end
        push_op(op);
      end else f_ill = 1;
    end
    if (!last) return;
    close_number();
    unwind(found);
    if (found) f_mal = 1;
    if (val_depth != 1) f_mal = 1;
    res.value = 0;
    if (balance != 0) res.status = cie_pkg::ST_PAREN;
    else if (f_ill) res.status = cie_pkg::ST_ILLEGAL;
    else if (f_dz) res.status = cie_pkg::ST_DIVZERO;
    else if (f_mal) res.status = cie_pkg::ST_MALFORMED;
    else if (f_ovf) res.status = cie_pkg::ST_OVERFLOW;
    else begin
      res.status = cie_pkg::ST_OK;
      res.value = vals[0];
    end
    expected_results = {expected_results, res};
    clear_state();
  endtask

  initial begin
    fail_count = 0;
    clear_state();
  end

  always @(posedge clk) begin
    eval_result_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) evaluate_char(in_char_code, in_last_char);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected item: value %0d status %0d", out_value, out_status);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_value !== e.value) begin
            $error("value: expected %0d actual %0d", e.value, out_value);
            fail_count++;
          end
          if (out_status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_status);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== test/checked_infix_expression_evaluator_unit_tb.sv =====
`timescale 1ns / 100ps

module checked_infix_expression_evaluator_unit_tb;

  logic                             clk = 0;
  logic                             rst_n = 0;
  logic                             in_valid = 0;
  logic                             in_stall;
  logic [7:0]                       in_char_code = 0;
  logic                             in_last_char = 0;
  logic                             out_valid;
  logic                             out_stall = 0;
  logic signed [cie_pkg::VAL_W-1:0] out_value;
  logic [2:0]                       out_status;
  int                               fail_count;
  int                               pending_results;
  int                               send_idle_pct = 0;
  int                               recv_stall_pct = 0;
  int                               hold_cycles = 0;
  int                               cycle_count = 0;
  byte unsigned                     line[$];

  checked_infix_expression_evaluator_unit dut (.*);
  checked_infix_expression_evaluator_unit_checker chk (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("[checked_infix_expression_evaluator_unit] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_char(logic [7:0] c, logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_char_code <= c;
    in_last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic byte unsigned pick_op();
    case ($urandom_range(3))
      0: return cie_pkg::CH_ADD;
      1: return cie_pkg::CH_SUB;
      2: return cie_pkg::CH_MUL;
      default: return cie_pkg::CH_DIV;
    endcase
  endfunction

  task automatic gen_number();
    int n;
    byte unsigned d;
    n = $urandom_range(9) == 0 ? $urandom_range(12, 5) : $urandom_range(3, 1);
    for (int i = 0; i < n; i++) begin
      d = 8'(cie_pkg::CH_ZERO + 8'($urandom_range(9)));
      line = {line, d};
    end
  endtask

  task automatic gen_expr(int lvl);
    int terms;
    byte unsigned c;
    terms = $urandom_range(4, 1);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) begin
        c = pick_op();
        line = {line, c};
      end
      if (lvl < 3 && $urandom_range(3) == 0) begin
        c = cie_pkg::CH_LPAREN;
        line = {line, c};
        gen_expr(lvl + 1);
        c = cie_pkg::CH_RPAREN;
        line = {line, c};
      end else gen_number();
    end
  endtask

  task automatic random_phase(int n_items);
    int sent;
    int k;
    byte unsigned c;
    sent = 0;
    while (sent < n_items) begin
      line.delete();
      if ($urandom_range(9) < 8) begin
        gen_expr(0);
        if ($urandom_range(9) == 0) begin
          k = $urandom_range(line.size() - 1);
          line[k] = $urandom_range(3) == 0 ? 8'($urandom) : pick_op();
        end
      end else begin
        k = $urandom_range(20, 1);
        for (int i = 0; i < k; i++) begin
          c = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(8'h28, 8'h39));
          line = {line, c};
        end
      end
      foreach (line[i]) send_char(line[i], i == line.size() - 1);
      sent += line.size();
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_results > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_text("7");
    send_text("2+3*4");
    send_text("(2+3)*4");
    send_text("8-3-2");
    send_text("7/2");
    send_text("1/0");
    send_text("((1)");
    send_text("1)");
    send_text("1 +2");
    send_text("+");
    send_text("(1+2)(");
    send_text("99999999999999*99999");
    send_text("4294967295*4294967295");
    send_text("0-2147483647-2147483647");
    send_text("1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1");
    send_text("((((((((((((((((((1))))))))))))))))))");
    send_text("1*(2*(3*(4*(5*(6*(7*(8*(9*(1*(2*(3*(4*(5*(6*(7*(8))))))))))))))))");
    send_char(8'hFF, 0);
    send_char(8'h00, 1);
    drain();
    random_phase(500);
    drain();
    send_idle_pct = 76;
    random_phase(350);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 76;
    random_phase(350);
    drain();
    send_idle_pct = 13;
    recv_stall_pct = 13;
    hold_cycles = 3000;
    random_phase(500);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(300);
    drain();
    if (fail_count == 0) $display("[checked_infix_expression_evaluator_unit] OK");
    else $display("[checked_infix_expression_evaluator_unit] ERROR");
    $finish;
  end
endmodule
